/* rtl/core/mer_pkg.sv */
// mer_pkg: shared types and constants of the execute unit with register file
// item payloads, operation codes, controller states and control structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int unsigned ResultW  = 32;
  localparam int unsigned ImmW     = 32;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned DestW    = 5;
  localparam int unsigned CmdW     = 5;
  localparam int unsigned ShamtW   = 5;
  localparam int unsigned NumGpr   = 32;
  localparam int unsigned LuiShift = 16;

  localparam logic [IdxW-1:0] IdxHi = 6'd32;
  localparam logic [IdxW-1:0] IdxLo = 6'd33;

  typedef enum logic [CmdW-1:0] {
    OpAdd  = 5'd0,
    OpSub  = 5'd1,
    OpAnd  = 5'd2,
    OpOr   = 5'd3,
    OpSll  = 5'd4,
    OpSra  = 5'd5,
    OpAddu = 5'd6,
    OpSubu = 5'd7,
    OpMul  = 5'd8,
    OpEq   = 5'd9,
    OpNe   = 5'd10,
    OpGt   = 5'd11,
    OpGe   = 5'd12,
    OpLt   = 5'd13,
    OpLe   = 5'd14,
    OpMult = 5'd15,
    OpDiv  = 5'd16,
    OpLui  = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StExec,
    StDiv,
    StWb
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]        command;
    logic [IdxW-1:0]        src_a_index;
    logic [IdxW-1:0]        src_b_index;
    logic                   use_immediate;
    logic signed [ImmW-1:0] immediate;
    logic [DestW-1:0]       dest_index;
  } in_item_t;

  typedef struct packed {
    logic signed [ResultW-1:0] result_value;
    logic                      condition;
    logic                      status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic operands;
    logic exec;
    logic div_step;
    logic wb;
  } dp_cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/mer_stream_if.sv */
// mer_stream_if: valid/ready channel carrying one item per transfer
// payload type is set per instance, normally from mer_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mer_stream_if #(
  parameter type item_t = logic
);

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

/* rtl/core/mer_datapath.sv */
// mer_datapath: register file, hi/lo, alu, multiplier, radix-2 divider, output register
// driven by mer_ctrl through mer_pkg::dp_cmd_t; uses mer_pkg
`timescale 1ns / 1ps
`default_nettype none

module mer_datapath #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  mer_pkg::dp_cmd_t     cmd_i,
  input  mer_pkg::in_item_t    in_data_i,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output mer_pkg::out_item_t   out_data_o,
  output mer_pkg::dp_status_t  status_o
);

  localparam int unsigned GprAw = $clog2(mer_pkg::NumGpr);
  localparam int unsigned CntW  = $clog2(DATA_WIDTH);
  localparam int unsigned ProdW = 2 * DATA_WIDTH;

  logic [DATA_WIDTH-1:0]     gpr_mem [mer_pkg::NumGpr];
  logic [mer_pkg::NumGpr-1:0] gpr_vld_q;
  logic [DATA_WIDTH-1:0]     hi_q, lo_q;

  mer_pkg::in_item_t         item_q;
  mer_pkg::op_e              op;
  logic [DATA_WIDTH-1:0]     mem_a_q, mem_b_q;
  logic                      vld_a_q, vld_b_q;
  logic [DATA_WIDTH-1:0]     op_a_d, op_b_d;
  logic [DATA_WIDTH-1:0]     op_a_q, op_b_q;
  logic signed [DATA_WIDTH-1:0] sa, sb;

  logic [DATA_WIDTH-1:0]     alu_d, alu_q;
  logic                      cond_d, cond_q;
  logic signed [ProdW-1:0]   prod_d, prod_q;
  logic [mer_pkg::ShamtW-1:0] shamt;

  logic [DATA_WIDTH-1:0]     a_mag, b_mag;
  logic [DATA_WIDTH-1:0]     div_rem_q, div_quo_q, div_dvs_q;
  logic [CntW-1:0]           div_cnt_q;
  logic                      div_qneg_q, div_rneg_q;
  logic [DATA_WIDTH:0]       rem_sh, trial;
  logic [DATA_WIDTH-1:0]     quot_fin, rem_fin;

  logic [DATA_WIDTH-1:0]     res_wb, hi_n, lo_n;
  logic                      cond_wb, stat_wb, gpr_we, hilo_we;

  logic                      out_valid_q;
  mer_pkg::out_item_t        out_data_q;

  function automatic logic [DATA_WIDTH-1:0] pick_reg(
    input logic [mer_pkg::IdxW-1:0] idx,
    input logic [DATA_WIDTH-1:0]    memd,
    input logic                     vld,
    input logic [DATA_WIDTH-1:0]    hi,
    input logic [DATA_WIDTH-1:0]    lo
  );
    logic [DATA_WIDTH-1:0] val;
    val = '0;
    if (!idx[mer_pkg::IdxW-1]) begin
      val = vld ? memd : '0;
    end else if (idx == mer_pkg::IdxHi) begin
      val = hi;
    end else if (idx == mer_pkg::IdxLo) begin
      val = lo;
    end
    return val;
  endfunction

  assign op = mer_pkg::op_e'(item_q.command);

  // register file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (gpr_we) begin
      gpr_mem[item_q.dest_index[GprAw-1:0]] <= res_wb;
    end
    if (cmd_i.load) begin
      mem_a_q <= gpr_mem[in_data_i.src_a_index[GprAw-1:0]];
      mem_b_q <= gpr_mem[in_data_i.src_b_index[GprAw-1:0]];
      vld_a_q <= gpr_vld_q[in_data_i.src_a_index[GprAw-1:0]];
      vld_b_q <= gpr_vld_q[in_data_i.src_b_index[GprAw-1:0]];
      item_q  <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_vld_q <= '0;
      hi_q      <= '0;
      lo_q      <= '0;
    end else begin
      if (gpr_we) begin
        gpr_vld_q[item_q.dest_index[GprAw-1:0]] <= 1'b1;
      end
      if (hilo_we) begin
        hi_q <= hi_n;
        lo_q <= lo_n;
      end
    end
  end

  // operand select
  always_comb begin
    op_a_d = pick_reg(item_q.src_a_index, mem_a_q, vld_a_q, hi_q, lo_q);
    op_b_d = item_q.use_immediate ? item_q.immediate[DATA_WIDTH-1:0]
                                  : pick_reg(item_q.src_b_index, mem_b_q, vld_b_q, hi_q, lo_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.operands) begin
      op_a_q <= op_a_d;
      op_b_q <= op_b_d;
    end
  end

  assign sa    = $signed(op_a_q);
  assign sb    = $signed(op_b_q);
  assign shamt = op_b_q[mer_pkg::ShamtW-1:0];

  // alu and compare
  always_comb begin
    alu_d  = '0;
    cond_d = 1'b0;
    unique case (op) inside
      mer_pkg::OpAdd, mer_pkg::OpAddu: alu_d = op_a_q + op_b_q;
      mer_pkg::OpSub, mer_pkg::OpSubu: alu_d = op_a_q - op_b_q;
      mer_pkg::OpAnd: alu_d = op_a_q & op_b_q;
      mer_pkg::OpOr:  alu_d = op_a_q | op_b_q;
      mer_pkg::OpSll: alu_d = op_a_q << shamt;
      mer_pkg::OpSra: alu_d = sa >>> shamt;
      mer_pkg::OpLui: alu_d = op_b_q << mer_pkg::LuiShift;
      mer_pkg::OpEq:  cond_d = (sa == sb);
      mer_pkg::OpNe:  cond_d = (sa != sb);
      mer_pkg::OpGt:  cond_d = (sa > sb);
      mer_pkg::OpGe:  cond_d = (sa >= sb);
      mer_pkg::OpLt:  cond_d = (sa < sb);
      mer_pkg::OpLe:  cond_d = (sa <= sb);
      default: begin
        alu_d  = '0;
        cond_d = 1'b0;
      end
    endcase
  end

  assign prod_d = sa * sb;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      alu_q  <= alu_d;
      cond_q <= cond_d;
      prod_q <= prod_d;
    end
  end

  // divider: restoring, one quotient bit per cycle on magnitudes
  assign a_mag  = sa[DATA_WIDTH-1] ? (~op_a_q + 1'b1) : op_a_q;
  assign b_mag  = sb[DATA_WIDTH-1] ? (~op_b_q + 1'b1) : op_b_q;
  assign rem_sh = {div_rem_q, div_quo_q[DATA_WIDTH-1]};
  assign trial  = rem_sh - {1'b0, div_dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      div_rem_q  <= '0;
      div_quo_q  <= a_mag;
      div_dvs_q  <= b_mag;
      div_cnt_q  <= CntW'(DATA_WIDTH - 1);
      div_qneg_q <= sa[DATA_WIDTH-1] ^ sb[DATA_WIDTH-1];
      div_rneg_q <= sa[DATA_WIDTH-1];
    end else if (cmd_i.div_step) begin
      if (!trial[DATA_WIDTH]) begin
        div_rem_q <= trial[DATA_WIDTH-1:0];
        div_quo_q <= {div_quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        div_rem_q <= rem_sh[DATA_WIDTH-1:0];
        div_quo_q <= {div_quo_q[DATA_WIDTH-2:0], 1'b0};
      end
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  assign quot_fin = div_qneg_q ? (~div_quo_q + 1'b1) : div_quo_q;
  assign rem_fin  = div_rneg_q ? (~div_rem_q + 1'b1) : div_rem_q;

  // write back
  always_comb begin
    res_wb  = '0;
    hi_n    = hi_q;
    lo_n    = lo_q;
    cond_wb = 1'b0;
    stat_wb = 1'b0;
    gpr_we  = 1'b0;
    hilo_we = 1'b0;
    unique case (op) inside
      mer_pkg::OpAdd, mer_pkg::OpSub, mer_pkg::OpAnd, mer_pkg::OpOr,
      mer_pkg::OpSll, mer_pkg::OpSra, mer_pkg::OpAddu, mer_pkg::OpSubu,
      mer_pkg::OpLui: begin
        res_wb = alu_q;
        gpr_we = cmd_i.wb && (item_q.dest_index != '0);
      end
      mer_pkg::OpMul: begin
        res_wb = prod_q[DATA_WIDTH-1:0];
        gpr_we = cmd_i.wb && (item_q.dest_index != '0);
      end
      mer_pkg::OpEq, mer_pkg::OpNe, mer_pkg::OpGt, mer_pkg::OpGe,
      mer_pkg::OpLt, mer_pkg::OpLe: begin
        cond_wb = cond_q;
        res_wb  = DATA_WIDTH'(cond_q);
      end
      mer_pkg::OpMult: begin
        hi_n    = prod_q[ProdW-1:DATA_WIDTH];
        lo_n    = prod_q[DATA_WIDTH-1:0];
        res_wb  = prod_q[DATA_WIDTH-1:0];
        hilo_we = cmd_i.wb;
      end
      mer_pkg::OpDiv: begin
        if (op_b_q == '0) begin
          stat_wb = 1'b1;
          res_wb  = lo_q;
        end else begin
          hi_n    = rem_fin;
          lo_n    = quot_fin;
          res_wb  = quot_fin;
          hilo_we = cmd_i.wb;
        end
      end
      default: begin
        res_wb = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wb) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      out_data_q.result_value <= mer_pkg::ResultW'($signed(res_wb));
      out_data_q.condition    <= cond_wb;
      out_data_q.status       <= stat_wb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.div_go   = (op == mer_pkg::OpDiv) && (op_b_q != '0);
  assign status_o.div_last = (div_cnt_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

/* rtl/core/mer_ctrl.sv */
// mer_ctrl: sequencer of the execute unit (accept, read, execute, divide, write back)
// drives mer_datapath through mer_pkg::dp_cmd_t; uses mer_pkg
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  mer_pkg::dp_status_t  status_i,
  output mer_pkg::dp_cmd_t     cmd_o
);

  mer_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mer_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      mer_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mer_pkg::StRead;
        end
      end
      mer_pkg::StRead: begin
        cmd_o.operands = 1'b1;
        state_d        = mer_pkg::StExec;
      end
      mer_pkg::StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.div_go ? mer_pkg::StDiv : mer_pkg::StWb;
      end
      mer_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = mer_pkg::StWb;
        end
      end
      mer_pkg::StWb: begin
        if (status_i.out_free) begin
          cmd_o.wb = 1'b1;
          state_d  = mer_pkg::StIdle;
        end
      end
      default: begin
        state_d = mer_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/mips_execute_alu_regfile.sv */
// mips_execute_alu_regfile: 32-bit execute unit with 32 general registers plus hi/lo
// instantiates mer_ctrl and mer_datapath; uses mer_pkg and mer_stream_if
//
//   port   dir   modport  payload              transfer when
//   in_i   in    sink     mer_pkg::in_item_t   in_i.valid & in_i.ready
//   out_o  out   source   mer_pkg::out_item_t  out_o.valid & out_o.ready
//
// one item at a time: accept, operand read, execute, write back; div adds divide
// steps for the one-bit-per-cycle divider, divide by zero does not
// registers read through a registered port of the register file, then through
// the operand registers; the result register holds until out_o.ready
// reset clears hi and lo, and all general registers at once via per-entry valid bits
// a stalled output holds the next result in write back, no state update is lost
`timescale 1ns / 1ps
`default_nettype none

module mips_execute_alu_regfile #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mer_stream_if.sink   in_i,
  mer_stream_if.source out_o
);

  mer_pkg::dp_cmd_t    dp_cmd;
  mer_pkg::dp_status_t dp_status;
  logic                in_ready;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  mer_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .status_o    (dp_status)
  );

  assign in_i.ready = in_ready;

  a_single_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while previous item in flight");

  a_cond_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.condition) |->
      (out_o.data.result_value == 32'sd1) && !out_o.data.status)
    else $error("condition set with inconsistent result");

  a_wb_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.wb |-> dp_status.out_free)
    else $error("write back over a pending result");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.div_step |-> !in_i.ready)
    else $error("input ready during divide");

endmodule

`default_nettype wire
